// ----- sv/csx_pkg.sv -----
// csx_pkg: shared types and constants for the CAN signal extract and scale unit
// holds payload structs, configuration register layout and pipeline stage records
// no dependencies
package csx_pkg;

    // payload and arithmetic widths
    localparam int BYTE_W          = 8;
    localparam int DATA_W          = 64;
    localparam int NUM_BYTES       = DATA_W / BYTE_W;
    localparam int LEN_W           = 4;
    localparam int START_W         = 3;
    localparam int COUNT_W         = 4;
    localparam int SCALE_W         = 32;
    localparam int ADJ_W           = 48;
    localparam int HALF_W          = DATA_W / 2;
    localparam int PROD_W          = DATA_W + SCALE_W;
    localparam int SUM_W           = PROD_W + 2;
    localparam int SHIFT_W         = $clog2(DATA_W) + 1;
    localparam int POP_W           = $clog2(DATA_W) + 1;
    localparam int CFG_IDX_W       = 3;
    localparam int NUM_STG         = 5;
    localparam int FRAME_BYTES_DEF = 8;

    // saturation limits of the Q48.16 result
    localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_BYTE,
        CFG_BYTE_COUNT,
        CFG_REVERSE,
        CFG_VALUE_MASK,
        CFG_IS_SIGNED,
        CFG_SCALE,
        CFG_ADJUST
    } t_cfg_idx;

    // input transaction
    typedef struct packed {
        logic [DATA_W-1:0] frame_bytes;
        logic [LEN_W-1:0]  frame_length;
    } t_in_item;

    // result transaction
    typedef struct packed {
        logic [DATA_W-1:0]        raw_field;
        logic                     is_negative;
        logic signed [DATA_W-1:0] scaled_value;
        logic                     saturated;
        logic                     range_error;
    } t_out_item;

    // configuration registers plus the derived sign region (bits at or above n-1)
    typedef struct packed {
        logic [START_W-1:0]       start_byte;
        logic [COUNT_W-1:0]       byte_count;
        logic                     reverse_order;
        logic [DATA_W-1:0]        value_mask;
        logic                     is_signed;
        logic signed [SCALE_W-1:0] scale_factor;
        logic signed [ADJ_W-1:0]  offset_adjust;
        logic [DATA_W-1:0]        sign_region;
    } t_cfg;

    // per-stage load enables
    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } t_stage_en;

    // after extraction
    typedef struct packed {
        logic [DATA_W-1:0] raw;
        logic [DATA_W-1:0] mag;
        logic              neg;
        logic              range_err;
    } t_ext_stage;

    // after partial products
    typedef struct packed {
        logic [DATA_W-1:0] p0;
        logic [DATA_W-1:0] p1;
        logic              flip;
        logic [DATA_W-1:0] raw;
        logic              neg;
        logic              range_err;
    } t_mul_stage;

    // after product assembly
    typedef struct packed {
        logic [PROD_W-1:0] prod;
        logic              flip;
        logic [DATA_W-1:0] raw;
        logic              neg;
        logic              range_err;
    } t_prod_stage;

endpackage

// ----- sv/csx_extract.sv -----
// csx_extract: byte slice, order, mask and sign handling stage
// depends on csx_pkg
module csx_extract #(
    parameter int P_FRAME_BYTES = csx_pkg::FRAME_BYTES_DEF
) (
    input  logic                  i_clk,
    input  csx_pkg::t_stage_en    i_en,
    input  csx_pkg::t_in_item     i_item,
    input  csx_pkg::t_cfg         i_cfg,
    output csx_pkg::t_ext_stage   o_ext
);
    import csx_pkg::*;

    logic [LEN_W-1:0]   len_eff;
    logic [LEN_W:0]     slice_end;
    logic [SHIFT_W-1:0] drop;
    logic [DATA_W-1:0]  shifted;
    logic [DATA_W-1:0]  little;
    logic [DATA_W-1:0]  swapped;
    logic [DATA_W-1:0]  fwd;
    logic [DATA_W-1:0]  joined;
    logic [DATA_W-1:0]  raw;
    logic               neg;
    t_ext_stage         n_ext;
    t_ext_stage         r_ext;

    // frame length clamp and slice bounds check
    always_comb begin
        len_eff = (i_item.frame_length > LEN_W'(P_FRAME_BYTES)) ?
                  LEN_W'(P_FRAME_BYTES) : i_item.frame_length;
        slice_end = (LEN_W+1)'(i_cfg.start_byte) + (LEN_W+1)'(i_cfg.byte_count);
    end

    // slice bytes: little-endian run, then byte-swapped for first-byte-msb order
    always_comb begin
        shifted = i_item.frame_bytes >> {i_cfg.start_byte, 3'b000};
        drop    = SHIFT_W'(DATA_W) - SHIFT_W'({i_cfg.byte_count, 3'b000});
        little  = shifted & ({DATA_W{1'b1}} >> drop);
        for (int b = 0; b < NUM_BYTES; b++) begin
            swapped[BYTE_W*b +: BYTE_W] = little[BYTE_W*(NUM_BYTES-1-b) +: BYTE_W];
        end
        fwd    = swapped >> drop;
        joined = i_cfg.reverse_order ? little : fwd;
        raw    = joined & i_cfg.value_mask;
        neg    = i_cfg.is_signed && (|(raw & i_cfg.sign_region));
    end

    // stage record, zeroed on a range error
    always_comb begin
        n_ext.range_err = (i_cfg.byte_count == '0) || (slice_end > (LEN_W+1)'(len_eff));
        if (n_ext.range_err) begin
            n_ext.raw = '0;
            n_ext.mag = '0;
            n_ext.neg = 1'b0;
        end else begin
            n_ext.raw = raw;
            n_ext.neg = neg;
            n_ext.mag = neg ? ((~raw & i_cfg.value_mask) + DATA_W'(1)) : raw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_ext <= n_ext;
        end
    end

    assign o_ext = r_ext;

endmodule

// ----- sv/csx_mul.sv -----
// csx_mul: 64 x 32 magnitude multiply as two 32 x 32 partial products, then assembly
// depends on csx_pkg
module csx_mul (
    input  logic                  i_clk,
    input  csx_pkg::t_stage_en    i_en,
    input  csx_pkg::t_ext_stage   i_ext,
    input  csx_pkg::t_cfg         i_cfg,
    output csx_pkg::t_prod_stage  o_prod
);
    import csx_pkg::*;

    logic               scale_neg;
    logic [SCALE_W-1:0] scale_mag;
    t_mul_stage         n_mul;
    t_mul_stage         r_mul;
    t_prod_stage        n_prod;
    t_prod_stage        r_prod;

    // scale magnitude and partial products
    always_comb begin
        scale_neg   = i_cfg.scale_factor[SCALE_W-1];
        scale_mag   = scale_neg ? (~i_cfg.scale_factor + SCALE_W'(1)) : i_cfg.scale_factor;
        n_mul.p0    = DATA_W'(i_ext.mag[HALF_W-1:0]) * DATA_W'(scale_mag);
        n_mul.p1    = DATA_W'(i_ext.mag[DATA_W-1:HALF_W]) * DATA_W'(scale_mag);
        n_mul.flip  = i_ext.neg ^ scale_neg;
        n_mul.raw   = i_ext.raw;
        n_mul.neg   = i_ext.neg;
        n_mul.range_err = i_ext.range_err;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_mul <= n_mul;
        end
    end

    // join partial products into the full magnitude product
    always_comb begin
        n_prod.prod = PROD_W'(r_mul.p0) + {r_mul.p1, {HALF_W{1'b0}}};
        n_prod.flip = r_mul.flip;
        n_prod.raw  = r_mul.raw;
        n_prod.neg  = r_mul.neg;
        n_prod.range_err = r_mul.range_err;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s4) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule

// ----- sv/csx_scale.sv -----
// csx_scale: sign apply, offset add and 64-bit saturation into the result register
// depends on csx_pkg
module csx_scale (
    input  logic                  i_clk,
    input  csx_pkg::t_stage_en    i_en,
    input  csx_pkg::t_prod_stage  i_prod,
    input  csx_pkg::t_cfg         i_cfg,
    output csx_pkg::t_out_item    o_item
);
    import csx_pkg::*;

    logic [SUM_W-1:0]  signed_prod;
    logic [SUM_W-1:0]  adj_ext;
    logic [SUM_W-1:0]  sum;
    logic              sat;
    t_out_item         n_out;
    t_out_item         r_out;

    // negate by inversion with carry-in, folded into the offset add
    always_comb begin
        signed_prod = i_prod.flip ? ~{2'b00, i_prod.prod} : {2'b00, i_prod.prod};
        adj_ext     = {{(SUM_W-ADJ_W){i_cfg.offset_adjust[ADJ_W-1]}}, i_cfg.offset_adjust};
        sum         = signed_prod + adj_ext + SUM_W'(i_prod.flip);
        sat         = !(&sum[SUM_W-1:DATA_W-1]) && (|sum[SUM_W-1:DATA_W-1]);
    end

    // result record
    always_comb begin
        n_out.range_error = i_prod.range_err;
        n_out.raw_field   = i_prod.raw;
        n_out.is_negative = i_prod.neg;
        if (i_prod.range_err) begin
            n_out.scaled_value = '0;
            n_out.saturated    = 1'b0;
        end else begin
            n_out.saturated    = sat;
            n_out.scaled_value = sat ? (sum[SUM_W-1] ? SAT_MIN : SAT_MAX) : sum[DATA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s5) begin
            r_out <= n_out;
        end
    end

    assign o_item = r_out;

endmodule

// ----- sv/can_signal_extract_scale_unit.sv -----
// can_signal_extract_scale_unit: top level with configuration registers and stage control
// depends on csx_pkg, csx_extract, csx_mul, csx_scale
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) carries one CAN payload and its
//   length per transaction. Output channel (o_out_valid / i_out_ready / o_out_data)
//   returns exactly one result transaction per input, in order.
//   Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data, one register
//   per cycle, while no transaction is in flight.
//   Pipeline: the input register is followed by extract, partial products, product
//   assembly, scale and saturate. Throughput: one transaction per cycle while the
//   receiver keeps i_out_ready high; the 64 x 32 multiply is split into two 32 x 32
//   partial products over two stages, so no stage limits the rate.
//   Each stage loads when it is empty or the stage after it moves, so bubbles are
//   squeezed out and inputs are still taken while a result waits on the output.
//   Receiver stall: a held result keeps o_out_data stable; once all five stages
//   are full, o_in_ready drops until i_out_ready returns.
//   Reset: synchronous, active low; empties the pipeline and loads the register
//   defaults (whole 8-byte frame, big-endian, full mask, unsigned, scale 1.0, no offset).
module can_signal_extract_scale_unit #(
    parameter int P_FRAME_BYTES = csx_pkg::FRAME_BYTES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  csx_pkg::t_in_item                 i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output csx_pkg::t_out_item                o_out_data,
    input  logic                              i_cfg_we,
    input  logic [csx_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [csx_pkg::DATA_W-1:0]        i_cfg_data
);
    import csx_pkg::*;

    t_cfg               r_cfg;
    t_in_item           r_in;
    logic [NUM_STG-1:0] r_vld;
    logic [NUM_STG-1:0] stg_adv;
    logic [POP_W-1:0]   mask_ones;
    t_stage_en          stg_en;
    t_ext_stage         ext;
    t_prod_stage        prod;

    function automatic logic [POP_W-1:0] count_ones(input logic [DATA_W-1:0] v);
        logic [POP_W-1:0] n;
        n = '0;
        for (int b = 0; b < DATA_W; b++) begin
            n = n + POP_W'(v[b]);
        end
        return n;
    endfunction

    // configuration writes; sign region derived from the mask popcount
    assign mask_ones = count_ones(i_cfg_data);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_byte    <= '0;
            r_cfg.byte_count    <= COUNT_W'(NUM_BYTES);
            r_cfg.reverse_order <= 1'b0;
            r_cfg.value_mask    <= {DATA_W{1'b1}};
            r_cfg.is_signed     <= 1'b0;
            r_cfg.scale_factor  <= SCALE_W'(65536);
            r_cfg.offset_adjust <= '0;
            r_cfg.sign_region   <= SAT_MIN;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_START_BYTE: r_cfg.start_byte    <= i_cfg_data[START_W-1:0];
                CFG_BYTE_COUNT: r_cfg.byte_count    <= i_cfg_data[COUNT_W-1:0];
                CFG_REVERSE:    r_cfg.reverse_order <= i_cfg_data[0];
                CFG_VALUE_MASK: begin
                    r_cfg.value_mask  <= i_cfg_data;
                    r_cfg.sign_region <= (mask_ones == '0) ? '0 :
                                         ({DATA_W{1'b1}} << (mask_ones - POP_W'(1)));
                end
                CFG_IS_SIGNED:  r_cfg.is_signed     <= i_cfg_data[0];
                CFG_SCALE:      r_cfg.scale_factor  <= i_cfg_data[SCALE_W-1:0];
                CFG_ADJUST:     r_cfg.offset_adjust <= i_cfg_data[ADJ_W-1:0];
                default: ;
            endcase
        end
    end

    // stage advance: a stage loads when empty or when the next one moves
    always_comb begin
        stg_adv[NUM_STG-1] = !r_vld[NUM_STG-1] || i_out_ready;
        for (int k = NUM_STG-2; k >= 0; k--) begin
            stg_adv[k] = !r_vld[k] || stg_adv[k+1];
        end
        stg_en.s2 = stg_adv[1];
        stg_en.s3 = stg_adv[2];
        stg_en.s4 = stg_adv[3];
        stg_en.s5 = stg_adv[4];
    end

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stg_adv[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NUM_STG; k++) begin
                if (stg_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (stg_adv[0]) begin
            r_in <= i_in_data;
        end
    end

    csx_extract #(
        .P_FRAME_BYTES (P_FRAME_BYTES)
    ) u_extract (
        .i_clk  (i_clk),
        .i_en   (stg_en),
        .i_item (r_in),
        .i_cfg  (r_cfg),
        .o_ext  (ext)
    );

    csx_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (stg_en),
        .i_ext  (ext),
        .i_cfg  (r_cfg),
        .o_prod (prod)
    );

    csx_scale u_scale (
        .i_clk  (i_clk),
        .i_en   (stg_en),
        .i_prod (prod),
        .i_cfg  (r_cfg),
        .o_item (o_out_data)
    );

    assign o_in_ready  = stg_adv[0];
    assign o_out_valid = r_vld[NUM_STG-1];

endmodule

// ----- sv/csx_checker.sv -----
// csx_checker: port-level assertions for the CAN signal extract and scale unit
// depends on csx_pkg; bound to can_signal_extract_scale_unit below
module csx_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input csx_pkg::t_in_item             i_in_data,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input csx_pkg::t_out_item            o_out_data,
    input logic                          i_cfg_we,
    input logic [csx_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input logic [csx_pkg::DATA_W-1:0]    i_cfg_data
);
    import csx_pkg::*;

    // pipeline is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // a stalled result transaction stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result dropped or changed");

    // range error clears every other field
    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.range_error |->
            o_out_data.raw_field == '0 && !o_out_data.is_negative &&
            o_out_data.scaled_value == '0 && !o_out_data.saturated)
        else $error("range error with nonzero fields");

    // a clamped result sits on one of the two limits
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.saturated |->
            o_out_data.scaled_value == SAT_MAX || o_out_data.scaled_value == SAT_MIN)
        else $error("saturated result off the limits");

    // a negative value needs a nonzero raw field
    a_neg_raw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.is_negative |-> o_out_data.raw_field != '0)
        else $error("negative flag with zero raw field");

endmodule

bind can_signal_extract_scale_unit csx_checker u_csx_checker (.*);
